// ===== hw/rtl/trc_pkg.sv =====
// ----------------------------------------------------------------------------
// Thermostat relay controller package
// Shared types and constants for the thermostat relay controller core.
// ----------------------------------------------------------------------------
package trc_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 7;

   localparam logic [CsrIndexWidth-1:0] CSR_NIGHT_SETPOINT = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_HYSTERESIS     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HOLD_TIME      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DAY_FIRST_HOUR = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_DAY_LAST_HOUR  = 3'd4;

   localparam logic [6:0] NIGHT_SETPOINT_RESET = 7'd34;
   localparam logic [4:0] HYSTERESIS_RESET     = 5'd2;
   localparam logic [5:0] HOLD_TIME_RESET      = 6'd10;
   localparam logic [4:0] DAY_FIRST_RESET      = 5'd7;
   localparam logic [4:0] DAY_LAST_RESET       = 5'd22;

   localparam logic [5:0] SETTING_OFF     = 6'd15;
   localparam logic [5:0] SETTING_BASE    = 6'd15;
   localparam logic [6:0] DAY_OFFSET      = 7'd15;
   localparam logic [4:0] KNOB_SCALE      = 5'd30;
   localparam logic [10:0] KNOB_FULL      = 11'd1023;
   localparam logic [7:0] MINUTES_PER_HOUR = 8'd60;
   localparam logic [7:0] BACKLIGHT_BRIGHT = 8'd255;
   localparam logic [7:0] BACKLIGHT_DIM    = 8'd5;

   typedef struct packed {
      logic [4:0]        clock_hour;
      logic [5:0]        clock_minute;
      logic [5:0]        clock_second;
      logic signed [8:0] room_temp_half;
      logic [9:0]        knob_raw;
   } tick_type;

   typedef struct packed {
      logic       heater_on;
      logic [7:0] backlight_level;
      logic       control_off;
      logic [6:0] target_half;
   } result_type;

   typedef struct packed {
      logic [6:0] night_setpoint_half;
      logic [4:0] hysteresis_half;
      logic [5:0] hold_time;
      logic [4:0] day_first_hour;
      logic [4:0] day_last_hour;
   } settings_type;

   // Elapsed time with a single wrap past sixty, the end of the minute or of the hour.
   function automatic logic signed [7:0] elapsed60(input logic [5:0] stored,
                                                   input logic [5:0] now);
      logic signed [7:0] result;
      if (stored > now) begin
         result = $signed(MINUTES_PER_HOUR - {2'b00, stored} + {2'b00, now});
      end else begin
         result = $signed({2'b00, now} - {2'b00, stored});
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/thermostat_relay_controller_core.sv =====
// Path: a tick is held in the input register, then its result in the result register.
// Throughput: one tick per cycle; the control state updates as a tick leaves the input register.
// A stalled result holds the result register, and then the input register, until it transfers.
// Reset (synchronous, active high) empties both registers, loads the default settings,
// turns the heater off, sets the backlight bright and clears the stored times and setting.
// ----------------------------------------------------------------------------
// Thermostat relay controller core
// Top level: input register, tick logic with settings, and result register.
// ----------------------------------------------------------------------------
module thermostat_relay_controller_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [4:0]                         req_clock_hour,
   input  logic [5:0]                         req_clock_minute,
   input  logic [5:0]                         req_clock_second,
   input  logic signed [8:0]                  req_room_temp_half,
   input  logic [9:0]                         req_knob_raw,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_heater_on,
   output logic [7:0]                         rsp_backlight_level,
   output logic                               rsp_control_off,
   output logic [6:0]                         rsp_target_half,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [trc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [trc_pkg::CsrDataWidth-1:0]   csr_wdata
);

   trc_pkg::tick_type     req_tick;
   trc_pkg::tick_type     tick;
   trc_pkg::settings_type settings;
   trc_pkg::result_type   result;
   trc_pkg::result_type   rsp_result;
   logic                  tick_valid;
   logic                  out_ready;

   assign csr_ready = 1'b1;

   assign req_tick.clock_hour     = req_clock_hour;
   assign req_tick.clock_minute   = req_clock_minute;
   assign req_tick.clock_second   = req_clock_second;
   assign req_tick.room_temp_half = req_room_temp_half;
   assign req_tick.knob_raw       = req_knob_raw;

   trc_settings u_settings (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .settings  (settings)
   );

   trc_input_stage u_input_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_tick         (req_tick),
      .downstream_ready (out_ready),
      .req_stall        (req_stall),
      .tick_valid       (tick_valid),
      .tick             (tick)
   );

   trc_tick_logic u_tick_logic (
      .clock     (clock),
      .reset     (reset),
      .tick_fire (tick_valid && out_ready),
      .tick      (tick),
      .settings  (settings),
      .result    (result)
   );

   trc_output_stage u_output_stage (
      .clock      (clock),
      .reset      (reset),
      .tick_valid (tick_valid),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .ready      (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_heater_on       = rsp_result.heater_on;
   assign rsp_backlight_level = rsp_result.backlight_level;
   assign rsp_control_off     = rsp_result.control_off;
   assign rsp_target_half     = rsp_result.target_half;

endmodule

// ===== hw/rtl/trc_settings.sv =====
// ----------------------------------------------------------------------------
// Thermostat relay controller settings
// Holds the configuration registers written through the CSR port.
// ----------------------------------------------------------------------------
module trc_settings (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [trc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [trc_pkg::CsrDataWidth-1:0]    csr_wdata,
   output trc_pkg::settings_type               settings
);

   trc_pkg::settings_type settings_ff;
   trc_pkg::settings_type settings_in;

   always_comb begin
      settings_in = settings_ff;
      if (csr_valid) begin
         unique case (csr_index)
            trc_pkg::CSR_NIGHT_SETPOINT: settings_in.night_setpoint_half = csr_wdata;
            trc_pkg::CSR_HYSTERESIS:     settings_in.hysteresis_half = csr_wdata[4:0];
            trc_pkg::CSR_HOLD_TIME:      settings_in.hold_time = csr_wdata[5:0];
            trc_pkg::CSR_DAY_FIRST_HOUR: settings_in.day_first_hour = csr_wdata[4:0];
            trc_pkg::CSR_DAY_LAST_HOUR:  settings_in.day_last_hour = csr_wdata[4:0];
            default: settings_in = settings_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settings_ff.night_setpoint_half <= trc_pkg::NIGHT_SETPOINT_RESET;
         settings_ff.hysteresis_half     <= trc_pkg::HYSTERESIS_RESET;
         settings_ff.hold_time           <= trc_pkg::HOLD_TIME_RESET;
         settings_ff.day_first_hour      <= trc_pkg::DAY_FIRST_RESET;
         settings_ff.day_last_hour       <= trc_pkg::DAY_LAST_RESET;
      end else begin
         settings_ff <= settings_in;
      end
   end

   assign settings = settings_ff;

endmodule

// ===== hw/rtl/trc_input_stage.sv =====
// ----------------------------------------------------------------------------
// Thermostat relay controller input stage
// Registers one tick from the request channel.
// ----------------------------------------------------------------------------
module trc_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  trc_pkg::tick_type req_tick,
   input  logic              downstream_ready,
   output logic              req_stall,
   output logic              tick_valid,
   output trc_pkg::tick_type tick
);

   logic              valid_ff;
   logic              valid_in;
   trc_pkg::tick_type tick_ff;
   logic              take;

   assign take      = !valid_ff || downstream_ready;
   assign req_stall = !take;
   assign valid_in  = take ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_valid) begin
         tick_ff <= req_tick;
      end
   end

   assign tick_valid = valid_ff;
   assign tick       = tick_ff;

endmodule

// ===== hw/rtl/trc_tick_logic.sv =====
// ----------------------------------------------------------------------------
// Thermostat relay controller tick logic
// Maps the knob, picks the target, decides the heater and keeps the timers.
// ----------------------------------------------------------------------------
module trc_tick_logic (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick_fire,
   input  trc_pkg::tick_type     tick,
   input  trc_pkg::settings_type settings,
   output trc_pkg::result_type   result
);

   logic [5:0] last_decision_minute_ff;
   logic [5:0] last_decision_minute_in;
   logic [5:0] last_change_second_ff;
   logic [5:0] last_change_second_in;
   logic [5:0] previous_setting_ff;
   logic [5:0] previous_setting_in;
   logic       heater_state_ff;
   logic       heater_state_in;
   logic       backlight_bright_ff;
   logic       backlight_bright_in;

   logic [14:0]       knob_scaled;
   logic [10:0]       knob_rem_sum;
   logic [5:0]        knob_quot;
   logic [5:0]        setting;
   logic              changed;
   logic              is_day;
   logic [6:0]        target;
   logic signed [7:0] sec_elapsed;
   logic signed [7:0] min_elapsed;
   logic signed [7:0] hold_signed;
   logic signed [9:0] threshold;
   logic signed [9:0] room_ext;

   // The product is split as a * 1024 + b, so a division by 1023 is a plus a carry.
   assign knob_scaled  = 15'(tick.knob_raw) * 15'(trc_pkg::KNOB_SCALE);
   assign knob_rem_sum = {1'b0, knob_scaled[9:0]} + 11'(knob_scaled[14:10]);
   assign knob_quot    = 6'(knob_scaled[14:10])
                         + 6'(knob_rem_sum >= trc_pkg::KNOB_FULL);
   assign setting      = trc_pkg::SETTING_BASE + knob_quot;
   assign changed      = setting != previous_setting_ff;

   assign is_day = (tick.clock_hour >= settings.day_first_hour)
                   && (tick.clock_hour <= settings.day_last_hour);
   assign target = is_day ? (7'(setting) + trc_pkg::DAY_OFFSET)
                          : settings.night_setpoint_half;

   assign sec_elapsed = trc_pkg::elapsed60(last_change_second_ff, tick.clock_second);
   assign min_elapsed = trc_pkg::elapsed60(last_decision_minute_ff, tick.clock_minute);
   assign hold_signed = $signed({2'b00, settings.hold_time});

   assign threshold = $signed({3'b000, target}) - $signed({5'b00000, settings.hysteresis_half});
   assign room_ext  = 10'(tick.room_temp_half);

   always_comb begin
      last_decision_minute_in = last_decision_minute_ff;
      last_change_second_in   = last_change_second_ff;
      previous_setting_in     = previous_setting_ff;
      heater_state_in         = heater_state_ff;
      backlight_bright_in     = backlight_bright_ff;
      if (setting == trc_pkg::SETTING_OFF) begin
         heater_state_in     = 1'b0;
         backlight_bright_in = 1'b0;
      end else begin
         if (sec_elapsed >= hold_signed) begin
            backlight_bright_in = 1'b0;
         end
         if (changed) begin
            backlight_bright_in   = 1'b1;
            last_change_second_in = tick.clock_second;
         end
         if (changed || (min_elapsed >= hold_signed)) begin
            heater_state_in         = room_ext < threshold;
            last_decision_minute_in = tick.clock_minute;
         end
         previous_setting_in = setting;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_decision_minute_ff <= '0;
         last_change_second_ff   <= '0;
         previous_setting_ff     <= '0;
         heater_state_ff         <= 1'b0;
         backlight_bright_ff     <= 1'b1;
      end else if (tick_fire) begin
         last_decision_minute_ff <= last_decision_minute_in;
         last_change_second_ff   <= last_change_second_in;
         previous_setting_ff     <= previous_setting_in;
         heater_state_ff         <= heater_state_in;
         backlight_bright_ff     <= backlight_bright_in;
      end
   end

   always_comb begin
      result.heater_on       = heater_state_in;
      result.backlight_level = backlight_bright_in ? trc_pkg::BACKLIGHT_BRIGHT
                                                   : trc_pkg::BACKLIGHT_DIM;
      result.control_off     = setting == trc_pkg::SETTING_OFF;
      result.target_half     = (setting == trc_pkg::SETTING_OFF) ? 7'd0 : target;
   end

endmodule

// ===== hw/rtl/trc_output_stage.sv =====
// ----------------------------------------------------------------------------
// Thermostat relay controller output stage
// Holds one result until the response channel takes it.
// ----------------------------------------------------------------------------
module trc_output_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                tick_valid,
   input  trc_pkg::result_type result,
   input  logic                rsp_stall,
   output logic                ready,
   output logic                rsp_valid,
   output trc_pkg::result_type rsp_result
);

   logic                valid_ff;
   logic                valid_in;
   trc_pkg::result_type result_ff;

   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = ready ? tick_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && tick_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule
